>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg
// Shared constants, function codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package crt_pkg;

  // Default sizing
  localparam int NUM_STAGES        = 7;
  localparam int ENTRIES_PER_STAGE = 64;
  localparam int VALUE_WIDTH       = 32;

  // Fixed field widths
  localparam int FUNC_W  = 2;
  localparam int STAGE_W = 3;
  localparam int INDEX_W = 6;
  localparam int CFG_W   = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd7;

  // Function codes of an input item
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD      = 2'd0,
    FUNC_TRANSLATE = 2'd1,
    FUNC_CLEAR     = 2'd2
  } func_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic in_ready;
    logic sweep_wr;
    logic load_wr;
    logic rd_en;
    logic hit_take;
    logic out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic              in_valid;
    logic              hit;
    logic              out_free;
    logic [FUNC_W-1:0] func;
    logic [CFG_W-1:0]  stages_eff;
  } status_t;

endpackage

>>> rtl/core/crt_in_if.sv
// ----------------------------------------------------------------------------
// crt_in_if
// Input channel: valid/ready handshake with one load, translate or clear item.
// ----------------------------------------------------------------------------
interface crt_in_if #(
  parameter int VW = crt_pkg::VALUE_WIDTH
);
  logic                        valid;
  logic                        ready;
  logic [crt_pkg::FUNC_W-1:0]  func;
  logic [crt_pkg::STAGE_W-1:0] stage;
  logic [crt_pkg::INDEX_W-1:0] entry_index;
  logic [VW-1:0]               dest_start;
  logic [VW-1:0]               src_start;
  logic [VW-1:0]               span_length;
  logic [VW-1:0]               value;

  modport source (
    output valid, func, stage, entry_index, dest_start, src_start, span_length, value,
    input  ready
  );

  modport sink (
    input  valid, func, stage, entry_index, dest_start, src_start, span_length, value,
    output ready
  );
endinterface

>>> rtl/core/crt_out_if.sv
// ----------------------------------------------------------------------------
// crt_out_if
// Result channel: valid/ready handshake with one result per input item.
// ----------------------------------------------------------------------------
interface crt_out_if #(
  parameter int VW = crt_pkg::VALUE_WIDTH
);
  logic          valid;
  logic          ready;
  logic [VW-1:0] mapped_value;
  logic [VW-1:0] min_value;
  logic          is_translation;

  modport source (
    output valid, mapped_value, min_value, is_translation,
    input  ready
  );

  modport sink (
    input  valid, mapped_value, min_value, is_translation,
    output ready
  );
endinterface

>>> rtl/core/crt_datapath.sv
// ----------------------------------------------------------------------------
// crt_datapath
// Entry memory, item registers, window compare, running minimum, result register.
// ----------------------------------------------------------------------------
module crt_datapath #(
  parameter int  NUM_STAGES        = crt_pkg::NUM_STAGES,
  parameter int  ENTRIES_PER_STAGE = crt_pkg::ENTRIES_PER_STAGE,
  parameter int  VALUE_WIDTH       = crt_pkg::VALUE_WIDTH,
  localparam int TOTAL             = NUM_STAGES * ENTRIES_PER_STAGE,
  localparam int AW                = (TOTAL > 1) ? $clog2(TOTAL) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  crt_pkg::cmd_t             cmd,
  input  logic [AW-1:0]             addr,
  output crt_pkg::status_t          status,
  input  logic                      cfg_we,
  input  logic [crt_pkg::CFG_W-1:0] cfg_wdata,
  crt_in_if.sink                    in_if,
  crt_out_if.source                 out_if
);

  localparam int VW = VALUE_WIDTH;
  localparam int MW = 3 * VW + 1;

  // Entry memory: {valid, dest_start, src_start, span_length}
  logic [MW-1:0] mem [TOTAL];
  logic [MW-1:0] rd_q_r;

  // Captured item
  logic [crt_pkg::FUNC_W-1:0]  func_r;
  logic [crt_pkg::STAGE_W-1:0] ld_stage_r;
  logic [crt_pkg::INDEX_W-1:0] ld_index_r;
  logic [VW-1:0]               dest_r;
  logic [VW-1:0]               src_r;
  logic [VW-1:0]               len_r;
  logic [VW-1:0]               v_r;

  logic [crt_pkg::CFG_W-1:0]   cfg_r;
  logic [VW-1:0]               min_r;

  logic                        out_valid_r;
  logic [VW-1:0]               out_mapped_r;
  logic [VW-1:0]               out_min_r;
  logic                        out_is_tr_r;

  logic                        accept;
  logic                        ld_ok;
  logic [AW-1:0]               ld_addr;
  logic                        rd_valid;
  logic [VW-1:0]               rd_dest;
  logic [VW-1:0]               rd_src;
  logic [VW-1:0]               rd_len;
  logic [VW-1:0]               offset;
  logic                        hit;
  logic [VW-1:0]               hit_val;
  logic [VW-1:0]               new_min;
  logic                        is_tr;

  assign accept = in_if.valid && in_if.ready;

  // Load target: ignore stages and slots beyond the table
  assign ld_ok   = (int'(ld_stage_r) < NUM_STAGES) && (int'(ld_index_r) < ENTRIES_PER_STAGE);
  assign ld_addr = AW'(int'(ld_stage_r) * ENTRIES_PER_STAGE + int'(ld_index_r));

  // Window compare on the entry read last cycle
  assign rd_valid = rd_q_r[MW-1];
  assign rd_dest  = rd_q_r[3*VW-1 -: VW];
  assign rd_src   = rd_q_r[2*VW-1 -: VW];
  assign rd_len   = rd_q_r[VW-1:0];
  assign offset   = v_r - rd_src;
  assign hit      = rd_valid && (v_r >= rd_src) && (offset < rd_len);
  assign hit_val  = rd_dest + offset;

  // Running minimum after this item
  assign is_tr = (func_r == crt_pkg::FUNC_TRANSLATE);
  always_comb begin
    case (func_r)
      crt_pkg::FUNC_TRANSLATE: new_min = (v_r < min_r) ? v_r : min_r;
      crt_pkg::FUNC_CLEAR:     new_min = '1;
      default:                 new_min = min_r;
    endcase
  end

  // Status back to the controller
  always_comb begin
    status.in_valid   = in_if.valid;
    status.hit        = hit;
    status.out_free   = !out_valid_r || out_if.ready;
    status.func       = func_r;
    status.stages_eff = (int'(cfg_r) > NUM_STAGES) ? crt_pkg::CFG_W'(NUM_STAGES) : cfg_r;
  end

  // Memory: clearing sweep or entry load on the write port, scan on the read port
  always_ff @(posedge clk) begin
    if (cmd.sweep_wr) begin
      mem[addr] <= '0;
    end else if (cmd.load_wr && ld_ok) begin
      mem[ld_addr] <= {1'b1, dest_r, src_r, len_r};
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[addr];
    end
  end

  // Capture the accepted item; advance the working value on a hit
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r     <= in_if.func;
      ld_stage_r <= in_if.stage;
      ld_index_r <= in_if.entry_index;
      dest_r     <= in_if.dest_start;
      src_r      <= in_if.src_start;
      len_r      <= in_if.span_length;
      v_r        <= in_if.value;
    end else if (cmd.hit_take) begin
      v_r <= hit_val;
    end
  end

  // Configuration register and running minimum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= crt_pkg::CFG_RESET;
      min_r <= '1;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (cmd.out_load) begin
        min_r <= new_min;
      end
    end
  end

  // Result register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_mapped_r <= is_tr ? v_r : '0;
      out_min_r    <= new_min;
      out_is_tr_r  <= is_tr;
    end
  end

  assign in_if.ready           = cmd.in_ready;
  assign out_if.valid          = out_valid_r;
  assign out_if.mapped_value   = out_mapped_r;
  assign out_if.min_value      = out_min_r;
  assign out_if.is_translation = out_is_tr_r;

endmodule

>>> rtl/core/crt_ctrl.sv
// ----------------------------------------------------------------------------
// crt_ctrl
// Sequencer: clearing sweep, item dispatch, stage-by-stage entry scan, result.
// ----------------------------------------------------------------------------
module crt_ctrl #(
  parameter int  NUM_STAGES        = crt_pkg::NUM_STAGES,
  parameter int  ENTRIES_PER_STAGE = crt_pkg::ENTRIES_PER_STAGE,
  localparam int TOTAL             = NUM_STAGES * ENTRIES_PER_STAGE,
  localparam int AW                = (TOTAL > 1) ? $clog2(TOTAL) : 1,
  localparam int SLW               = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  crt_pkg::status_t status,
  output crt_pkg::cmd_t    cmd,
  output logic [AW-1:0]    addr
);

  localparam int CW = crt_pkg::CFG_W;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [SLW-1:0] slot_r, slot_nxt;
  logic [CW-1:0] stage_r, stage_nxt;
  logic          issuing_r, issuing_nxt;
  logic          inflight_r, inflight_nxt;
  logic          last_r, last_nxt;
  logic          skip_r, skip_nxt;

  logic          checked;
  logic          stage_done;
  logic          final_stage;
  logic          slot_last;

  // A read that came back and was not killed by an earlier hit
  assign checked     = (state_r == ST_SCAN) && inflight_r && !skip_r;
  assign stage_done  = checked && (status.hit || last_r);
  assign final_stage = (({1'b0, stage_r} + (CW+1)'(1)) >= {1'b0, status.stages_eff});
  assign slot_last   = (slot_r == SLW'(ENTRIES_PER_STAGE - 1));

  // Commands
  always_comb begin
    cmd          = '0;
    cmd.in_ready = (state_r == ST_IDLE);
    cmd.sweep_wr = (state_r == ST_SWEEP);
    cmd.load_wr  = (state_r == ST_EXEC) && (status.func == crt_pkg::FUNC_LOAD);
    cmd.rd_en    = (state_r == ST_SCAN) && issuing_r;
    cmd.hit_take = checked && status.hit;
    cmd.out_load = (state_r == ST_FINISH) && status.out_free;
  end

  assign addr = addr_r;

  // Next state
  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    base_nxt     = base_r;
    slot_nxt     = slot_r;
    stage_nxt    = stage_r;
    issuing_nxt  = issuing_r;
    inflight_nxt = 1'b0;
    last_nxt     = 1'b0;
    skip_nxt     = 1'b0;
    case (state_r)
      ST_SWEEP: begin
        if (addr_r == AW'(TOTAL - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (status.in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_FINISH;
        if (status.func == crt_pkg::FUNC_TRANSLATE && status.stages_eff != '0) begin
          state_nxt   = ST_SCAN;
          addr_nxt    = '0;
          base_nxt    = '0;
          slot_nxt    = '0;
          stage_nxt   = '0;
          issuing_nxt = 1'b1;
        end
      end
      ST_SCAN: begin
        inflight_nxt = cmd.rd_en;
        last_nxt     = cmd.rd_en && slot_last;
        // Drop the read issued alongside a hit
        skip_nxt     = cmd.rd_en && cmd.hit_take;
        if (stage_done) begin
          if (final_stage) begin
            state_nxt   = ST_FINISH;
            issuing_nxt = 1'b0;
          end else begin
            stage_nxt   = stage_r + CW'(1);
            base_nxt    = base_r + AW'(ENTRIES_PER_STAGE);
            addr_nxt    = base_r + AW'(ENTRIES_PER_STAGE);
            slot_nxt    = '0;
            issuing_nxt = 1'b1;
          end
        end else if (cmd.rd_en) begin
          addr_nxt = addr_r + AW'(1);
          slot_nxt = slot_r + SLW'(1);
          if (slot_last) begin
            issuing_nxt = 1'b0;
          end
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_SWEEP;
      addr_r     <= '0;
      base_r     <= '0;
      slot_r     <= '0;
      stage_r    <= '0;
      issuing_r  <= 1'b0;
      inflight_r <= 1'b0;
      last_r     <= 1'b0;
      skip_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      addr_r     <= addr_nxt;
      base_r     <= base_nxt;
      slot_r     <= slot_nxt;
      stage_r    <= stage_nxt;
      issuing_r  <= issuing_nxt;
      inflight_r <= inflight_nxt;
      last_r     <= last_nxt;
      skip_r     <= skip_nxt;
    end
  end

endmodule

>>> rtl/core/chained_range_translation_unit.sv
// ----------------------------------------------------------------------------
// chained_range_translation_unit
// Cascade of range-translation tables with a running minimum of results.
// ----------------------------------------------------------------------------
// Works on one item at a time and returns one result per item. A load or a
// clear passes from the idle state through the execute state to the result
// state, where the result register is loaded. A translate reads the entry
// memory once per cycle, one entry after another, through each stage in use:
// a stage is scanned up to its first hit or its last slot, and the stages are
// scanned in order before the result state. Each result becomes valid in the
// same cycle as the block returns to idle and can take the next item; the
// scan is serial because the entry memory has a single read port.
// While the previous result still waits on the result side, the block holds
// in its result state. After reset the block clears the valid marks with a
// sweep over all NUM_STAGES * ENTRIES_PER_STAGE entries (448 by default)
// before it takes the first item; configuration writes are taken during the
// sweep.
// ----------------------------------------------------------------------------
module chained_range_translation_unit #(
  parameter int  NUM_STAGES        = crt_pkg::NUM_STAGES,
  parameter int  ENTRIES_PER_STAGE = crt_pkg::ENTRIES_PER_STAGE,
  parameter int  VALUE_WIDTH       = crt_pkg::VALUE_WIDTH,
  localparam int TOTAL             = NUM_STAGES * ENTRIES_PER_STAGE,
  localparam int AW                = (TOTAL > 1) ? $clog2(TOTAL) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [crt_pkg::CFG_W-1:0] cfg_wdata,
  crt_in_if.sink                    in_if,
  crt_out_if.source                 out_if
);

  crt_pkg::cmd_t    cmd;
  crt_pkg::status_t status;
  logic [AW-1:0]    addr;
  logic             min_in_order;

  // Sequencer
  crt_ctrl #(
    .NUM_STAGES        (NUM_STAGES),
    .ENTRIES_PER_STAGE (ENTRIES_PER_STAGE)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd),
    .addr   (addr)
  );

  // Storage and arithmetic
  crt_datapath #(
    .NUM_STAGES        (NUM_STAGES),
    .ENTRIES_PER_STAGE (ENTRIES_PER_STAGE),
    .VALUE_WIDTH       (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .addr      (addr),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .out_if    (out_if)
  );

  // A translate result never sits below its own running minimum
  assign min_in_order = !out_if.is_translation || (out_if.min_value <= out_if.mapped_value);

  `include "assert_macros.svh"

  `ASSERT_IMPLIES(a_sweep_blocks_input, cmd.sweep_wr, !in_if.ready, "item taken during sweep")
  `ASSERT_ALWAYS(a_one_writer, !(cmd.sweep_wr && cmd.load_wr), "sweep and load write together")
  `ASSERT_NEXT(a_one_item, in_if.valid && in_if.ready, !in_if.ready, "second item taken early")
  `ASSERT_IMPLIES(a_min_bound, out_if.valid, min_in_order, "minimum above result")

endmodule

>>> dv/chained_range_translation_unit_tb.sv
// ----------------------------------------------------------------------------
// chained_range_translation_unit_tb
// Self-checking bench for the chained range translation unit: a directed table
// of loads, translates and clears, then random phases at several stage counts,
// every result checked in order against a fixed value or the in-bench model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module chained_range_translation_unit_tb;

  localparam int NUM_STAGES        = crt_pkg::NUM_STAGES;
  localparam int ENTRIES_PER_STAGE = crt_pkg::ENTRIES_PER_STAGE;
  localparam int VALUE_WIDTH       = crt_pkg::VALUE_WIDTH;
  localparam int FUNC_W            = crt_pkg::FUNC_W;
  localparam int STAGE_W           = crt_pkg::STAGE_W;
  localparam int INDEX_W           = crt_pkg::INDEX_W;
  localparam int CFG_W             = crt_pkg::CFG_W;

  localparam int              TOTAL_SLOTS  = NUM_STAGES * ENTRIES_PER_STAGE;
  localparam logic [1:0]      FUNC_UNUSED  = 2'd3;
  localparam logic [VALUE_WIDTH-1:0] ALL_ONES = '1;
  localparam int              CYCLE_LIMIT  = 2_500_000;
  localparam int              DRAIN_CYCLES = 3 + NUM_STAGES * (ENTRIES_PER_STAGE + 1) + 40;
  localparam int              PHASES       = 9;
  localparam int              PHASE_ITEMS  = 110;
  localparam int              MAX_SHOWN    = 10;

  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic [STAGE_W-1:0]     stage;
    logic [INDEX_W-1:0]     entry_index;
    logic [VALUE_WIDTH-1:0] dest_start;
    logic [VALUE_WIDTH-1:0] src_start;
    logic [VALUE_WIDTH-1:0] span_length;
    logic [VALUE_WIDTH-1:0] value;
  } item_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] mapped_value;
    logic [VALUE_WIDTH-1:0] min_value;
    logic                   is_translation;
  } result_t;

  typedef struct {
    bit               is_cfg;
    logic [CFG_W-1:0] cfg_val;
    item_t            it;
    bit               fixed_exp;
    result_t          want;
  } plan_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  crt_in_if  in_ch ();
  crt_out_if out_ch ();

  chained_range_translation_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  // Translation model state
  logic [VALUE_WIDTH-1:0] dest_tab [TOTAL_SLOTS];
  logic [VALUE_WIDTH-1:0] src_tab  [TOTAL_SLOTS];
  logic [VALUE_WIDTH-1:0] len_tab  [TOTAL_SLOTS];
  bit                     vld_tab  [TOTAL_SLOTS];
  logic [VALUE_WIDTH-1:0] min_seen;
  logic [CFG_W-1:0]       stages_cfg;

  result_t   pending_results [$];
  plan_row_t directed_plan [$];
  int        error_count;
  int        shown_count;
  int        cycle_count;
  bit        calm_in;
  bit        calm_out;

  // Clock: 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Apply one stage: first valid slot whose window holds the value wins
  function automatic logic [VALUE_WIDTH-1:0] through_stage(input int st,
                                                           input logic [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH-1:0] r;
    bit                     hit;
    int                     slot;
    r   = v;
    hit = 1'b0;
    for (int k = 0; k < ENTRIES_PER_STAGE; k++) begin
      slot = st * ENTRIES_PER_STAGE + k;
      if (!hit && vld_tab[slot] && v >= src_tab[slot] && (v - src_tab[slot]) < len_tab[slot]) begin
        r   = dest_tab[slot] + (v - src_tab[slot]);
        hit = 1'b1;
      end
    end
    return r;
  endfunction

  // Advance the model by one item and return the result it causes
  function automatic result_t map_item(input item_t it);
    result_t                r;
    logic [VALUE_WIDTH-1:0] v;
    int                     n;
    int                     slot;
    r.mapped_value   = '0;
    r.is_translation = 1'b0;
    if (it.func == crt_pkg::FUNC_LOAD) begin
      if (it.stage < NUM_STAGES && it.entry_index < ENTRIES_PER_STAGE) begin
        slot           = it.stage * ENTRIES_PER_STAGE + it.entry_index;
        dest_tab[slot] = it.dest_start;
        src_tab[slot]  = it.src_start;
        len_tab[slot]  = it.span_length;
        vld_tab[slot]  = 1'b1;
      end
    end else if (it.func == crt_pkg::FUNC_TRANSLATE) begin
      n = (stages_cfg > NUM_STAGES) ? NUM_STAGES : stages_cfg;
      v = it.value;
      for (int st = 0; st < n; st++) v = through_stage(st, v);
      if (v < min_seen) min_seen = v;
      r.mapped_value   = v;
      r.is_translation = 1'b1;
    end else if (it.func == crt_pkg::FUNC_CLEAR) begin
      min_seen = ALL_ONES;
    end
    r.min_value = min_seen;
    return r;
  endfunction

  // Idle length for one transfer; occasionally toggle a stretch with no idling
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [CFG_W-1:0] phase_stages(input int p);
    case (p)
      0:       return 3'd7;
      1:       return 3'd1;
      2:       return 3'd0;
      3:       return 3'd3;
      4:       return 3'd7;
      5:       return 3'd5;
      6:       return 3'd2;
      7:       return 3'd6;
      default: return 3'd4;
    endcase
  endfunction

  // Random item: mostly narrow values so windows chain, some full-width noise
  function automatic item_t random_item();
    item_t it;
    int    r;
    bit    narrow;
    int    k;
    int    slot;
    bit    found;
    it.func        = crt_pkg::FUNC_LOAD;
    it.stage       = $urandom;
    it.entry_index = $urandom;
    it.dest_start  = $urandom;
    it.src_start   = $urandom;
    it.span_length = $urandom;
    it.value       = $urandom;
    r      = $urandom_range(0, 99);
    narrow = ($urandom_range(0, 3) != 0);
    if (r < 45) begin
      it.func  = crt_pkg::FUNC_LOAD;
      it.stage = ($urandom_range(0, 49) == 0) ? 3'd7 : $urandom_range(0, NUM_STAGES - 1);
      it.entry_index = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
      if (narrow) begin
        it.dest_start  = $urandom_range(0, 4095);
        it.src_start   = $urandom_range(0, 4095);
        it.span_length = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 768);
      end
    end else if (r < 88) begin
      it.func = crt_pkg::FUNC_TRANSLATE;
      found   = 1'b0;
      if ($urandom_range(0, 1) == 0) begin
        k = $urandom_range(0, ENTRIES_PER_STAGE - 1);
        for (int j = 0; j < ENTRIES_PER_STAGE; j++) begin
          slot = (k + j) % ENTRIES_PER_STAGE;
          if (!found && vld_tab[slot] && len_tab[slot] != 0) begin
            it.value = src_tab[slot] + ($urandom % len_tab[slot]);
            found    = 1'b1;
          end
        end
      end
      if (!found && narrow) it.value = $urandom_range(0, 4095);
    end else if (r < 96) begin
      it.func = crt_pkg::FUNC_CLEAR;
    end else begin
      it.func = FUNC_UNUSED;
    end
    return it;
  endfunction

  // Queue one expected result behind those already waiting
  task automatic expect_result(input result_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic add_cfg(input logic [CFG_W-1:0] n);
    plan_row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.cfg_val = n;
    directed_plan.insert(directed_plan.size(), row);
  endtask

  task automatic add_item(input logic [FUNC_W-1:0] f, input logic [STAGE_W-1:0] st,
                          input logic [INDEX_W-1:0] ix, input logic [VALUE_WIDTH-1:0] d,
                          input logic [VALUE_WIDTH-1:0] s, input logic [VALUE_WIDTH-1:0] l,
                          input logic [VALUE_WIDTH-1:0] v, input bit fixed,
                          input logic [VALUE_WIDTH-1:0] em, input logic [VALUE_WIDTH-1:0] emin,
                          input logic et);
    plan_row_t row;
    row           = '{default: '0};
    row.it        = '{func: f, stage: st, entry_index: ix, dest_start: d, src_start: s,
                      span_length: l, value: v};
    row.fixed_exp = fixed;
    row.want      = '{mapped_value: em, min_value: emin, is_translation: et};
    directed_plan.insert(directed_plan.size(), row);
  endtask

  // Drive one item and hold it until the transfer
  task automatic send_item(input item_t it);
    int gap;
    gap = draw_wait(calm_in);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= it.func;
    in_ch.stage       <= it.stage;
    in_ch.entry_index <= it.entry_index;
    in_ch.dest_start  <= it.dest_start;
    in_ch.src_start   <= it.src_start;
    in_ch.span_length <= it.span_length;
    in_ch.value       <= it.value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Write the stage count once the block has drained
  task automatic write_stages(input logic [CFG_W-1:0] n);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we     <= 1'b0;
    stages_cfg  = n;
  endtask

  task automatic note_error(input string msg);
    error_count++;
    if (shown_count < MAX_SHOWN) begin
      shown_count++;
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // Compare one result transfer with the oldest expectation
  task automatic check_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      note_error($sformatf("unexpected result mapped %h min %h tr %b",
                           got.mapped_value, got.min_value, got.is_translation));
    end else begin
      want = pending_results.pop_front();
      if (got.mapped_value !== want.mapped_value || got.min_value !== want.min_value ||
          got.is_translation !== want.is_translation) begin
        note_error($sformatf("mapped exp %h got %h, min exp %h got %h, tr exp %b got %b",
                             want.mapped_value, got.mapped_value, want.min_value,
                             got.min_value, want.is_translation, got.is_translation));
      end
    end
  endtask

  // Timeout
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stalls, check every transfer
  initial begin
    int      stall;
    result_t got;
    calm_out      = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(calm_out);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.mapped_value   = out_ch.mapped_value;
      got.min_value      = out_ch.min_value;
      got.is_translation = out_ch.is_translation;
      check_result(got);
    end
  end

  // Stimulus
  initial begin
    item_t   it;
    result_t r;
    int      counted;
    error_count = 0;
    shown_count = 0;
    calm_in     = 1'b0;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= crt_pkg::CFG_RESET;
    in_ch.valid       <= 1'b0;
    in_ch.func        <= crt_pkg::FUNC_LOAD;
    in_ch.stage       <= '0;
    in_ch.entry_index <= '0;
    in_ch.dest_start  <= '0;
    in_ch.src_start   <= '0;
    in_ch.span_length <= '0;
    in_ch.value       <= '0;

    // Reset state of the model
    for (int i = 0; i < TOTAL_SLOTS; i++) begin
      dest_tab[i] = '0;
      src_tab[i]  = '0;
      len_tab[i]  = '0;
      vld_tab[i]  = 1'b0;
    end
    min_seen   = ALL_ONES;
    stages_cfg = crt_pkg::CFG_RESET;

    // Directed plan: after-reset values, ignored items, windows and chaining
    add_cfg(3'd7);
    add_item(crt_pkg::FUNC_TRANSLATE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF,
             1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    add_item(crt_pkg::FUNC_TRANSLATE, 0, 0, 0, 0, 0, 32'h0, 1, 32'h0, 32'h0, 1);
    add_item(crt_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 1, 32'h0, 32'hFFFF_FFFF, 0);
    add_item(FUNC_UNUSED, 3'd2, 6'd7, 32'h5555_AAAA, 32'h0, 32'hFFFF_FFFF, 32'h1,
             1, 32'h0, 32'hFFFF_FFFF, 0);
    add_item(crt_pkg::FUNC_LOAD, 3'd7, 6'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0,
             1, 32'h0, 32'hFFFF_FFFF, 0);
    add_item(crt_pkg::FUNC_TRANSLATE, 0, 0, 0, 0, 0, 32'h5, 1, 32'h5, 32'h5, 1);
    // empty window in the last slot
    add_item(crt_pkg::FUNC_LOAD, 3'd0, 6'd63, 32'h64, 32'h0, 32'h0, 32'h0,
             1, 32'h0, 32'h5, 0);
    add_item(crt_pkg::FUNC_TRANSLATE, 0, 0, 0, 0, 0, 32'h0, 1, 32'h0, 32'h0, 1);
    add_item(crt_pkg::FUNC_LOAD, 3'd0, 6'd10, 32'h1000, 32'h10, 32'h10, 32'h0, 0, 0, 0, 0);
    add_item(crt_pkg::FUNC_TRANSLATE, 0, 0, 0, 0, 0, 32'h18, 0, 0, 0, 0);
    add_item(crt_pkg::FUNC_TRANSLATE, 0, 0, 0, 0, 0, 32'h20, 0, 0, 0, 0);
    // lower slot overlapping, result wraps past the top
    add_item(crt_pkg::FUNC_LOAD, 3'd0, 6'd5, 32'hFFFF_FFF0, 32'h14, 32'h100, 32'h0,
             0, 0, 0, 0);
    add_item(crt_pkg::FUNC_TRANSLATE, 0, 0, 0, 0, 0, 32'h18, 0, 0, 0, 0);
    add_item(crt_pkg::FUNC_TRANSLATE, 0, 0, 0, 0, 0, 32'h30, 0, 0, 0, 0);
    // window running past the largest value
    add_item(crt_pkg::FUNC_LOAD, 3'd1, 6'd0, 32'h0, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h0,
             0, 0, 0, 0);
    add_item(crt_pkg::FUNC_TRANSLATE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
    // overwrite a slot, then chain into the last stage
    add_item(crt_pkg::FUNC_LOAD, 3'd0, 6'd5, 32'h200, 32'h14, 32'h1, 32'h0, 0, 0, 0, 0);
    add_item(crt_pkg::FUNC_TRANSLATE, 0, 0, 0, 0, 0, 32'h14, 0, 0, 0, 0);
    add_item(crt_pkg::FUNC_LOAD, 3'd6, 6'd63, 32'hABCD_0000, 32'h200, 32'h1, 32'h0,
             0, 0, 0, 0);
    add_item(crt_pkg::FUNC_TRANSLATE, 0, 0, 0, 0, 0, 32'h14, 0, 0, 0, 0);
    // no stage in use, then one stage
    add_cfg(3'd0);
    add_item(crt_pkg::FUNC_TRANSLATE, 0, 0, 0, 0, 0, 32'h14, 0, 0, 0, 0);
    add_cfg(3'd1);
    add_item(crt_pkg::FUNC_TRANSLATE, 0, 0, 0, 0, 0, 32'h14, 0, 0, 0, 0);
    add_item(crt_pkg::FUNC_LOAD, 3'd3, 6'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1,
             32'hFFFF_FFFF, 0, 0, 0, 0);
    add_item(crt_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 1, 32'h0, 32'hFFFF_FFFF, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed plan
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        write_stages(directed_plan[i].cfg_val);
      end else begin
        send_item(directed_plan[i].it);
        r = map_item(directed_plan[i].it);
        if (directed_plan[i].fixed_exp) r = directed_plan[i].want;
        expect_result(r);
      end
    end

    // Random phases, one stage count each
    for (int p = 0; p < PHASES; p++) begin
      write_stages(phase_stages(p));
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = random_item();
        send_item(it);
        expect_result(map_item(it));
        if (!(it.func == FUNC_UNUSED ||
              (it.func == crt_pkg::FUNC_LOAD && it.stage >= NUM_STAGES)))
          counted++;
      end
    end

    // Drain
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_results.size()));

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/crt_pkg.sv
rtl/core/crt_in_if.sv
rtl/core/crt_out_if.sv
rtl/core/crt_datapath.sv
rtl/core/crt_ctrl.sv
rtl/core/chained_range_translation_unit.sv
dv/chained_range_translation_unit_tb.sv
